>>> src/bfm_pkg.sv
// shared constants and pipeline side-band types for the brush falloff mask
`default_nettype none
package bfm_pkg;
    localparam int FRAC_BITS = 16;
    localparam int MAX_SIZE  = 1024;
    localparam int SIZE_W    = 11;
    localparam int COORD_W   = 10;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int D2_W      = 20;
    localparam int SQ_IN_W   = D2_W + 2 * FRAC_BITS;
    localparam int ROOT_W    = SQ_IN_W / 2;
    localparam int RMIN_W    = 28;
    localparam int DR_W      = 27;
    localparam int NUM_W     = 29;
    localparam int QUO_W     = FRAC_BITS;
    localparam longint unsigned ONE_L = longint'(1) << FRAC_BITS;
    localparam longint unsigned K_L   = (ONE_L * 99999) / 100000;
    localparam logic [Q_W-1:0]  ONE_Q = Q_W'(ONE_L);
    localparam logic [Q_W:0]    K_Q   = (Q_W + 1)'(K_L);
    localparam logic [Q_W:0]    ONE_MINUS_K = (Q_W + 1)'(ONE_L - K_L);

    localparam logic [1:0] REG_SIZE   = 2'd0;
    localparam logic [1:0] REG_SMOOTH = 2'd1;
    localparam logic [1:0] REG_OPAC   = 2'd2;

    typedef struct packed {
        logic                     vld;
        logic                     zero;
        logic signed [RMIN_W-1:0] rmin;
        logic [DR_W-1:0]          dr;
    } t_sq_side;

    typedef struct packed {
        logic vld;
        logic zero;
        logic one;
    } t_dv_side;
endpackage
`default_nettype wire

>>> src/brush_falloff_mask.sv
// Radial brush falloff mask: one Q1.16 weight per (col, row) pixel word, scaled by
// opacity. The block is a fixed pipeline that takes one pixel word every clock while
// the output is not stalled (1 setup stage, 26 square-root stages, 1 compare stage,
// 16 divider stages, 1 falloff stage, 1 opacity stage). It advances as a whole while
// the output register is empty or being taken; o_s_tready is high exactly then. The
// user must write configuration through the cfg port while no pixel is in flight (not
// enforced by the block): index 0 brush size, 1 smoothness, 2 opacity; others ignored.
`default_nettype none
module brush_falloff_mask (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // col[9:0], row[19:10], zero fill
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // weight[16:0], zero fill
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data
);
    import bfm_pkg::*;

    logic [SIZE_W-1:0] r_size;
    logic [Q_W-1:0]    r_smooth;
    logic [Q_W-1:0]    r_opac;
    logic              en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= SIZE_W'(16);
            r_smooth <= '0;
            r_opac   <= ONE_Q;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SIZE:   r_size   <= i_cfg_data[SIZE_W-1:0];
                REG_SMOOTH: r_smooth <= i_cfg_data[Q_W-1:0];
                REG_OPAC:   r_opac   <= i_cfg_data[Q_W-1:0];
                default:    ;
            endcase
        end
    end

    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // setup stage: distance squared and falloff bounds
    logic [COORD_W-1:0]   col, row;
    logic [SIZE_W-1:0]    size;
    logic [COORD_W-1:0]   xc;
    logic signed [SIZE_W:0] dx, dy;
    logic [D2_W-1:0]      d2;
    logic signed [Q_W+1:0] kms;
    t_sq_side             n_sq;
    t_sq_side             r_sq;
    logic [D2_W-1:0]      r_d2;

    always_comb begin
        col  = i_s_tdata[COORD_W-1:0];
        row  = i_s_tdata[2*COORD_W-1:COORD_W];
        size = (r_size > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : r_size;
        xc   = COORD_W'(size >> 1);
        dx   = $signed({2'b0, col}) - $signed({2'b0, xc});
        dy   = $signed({2'b0, row}) - $signed({2'b0, xc});
        d2   = D2_W'(dx * dx) + D2_W'(dy * dy);
        kms  = $signed({1'b0, K_Q}) - $signed({2'b0, r_smooth});
        n_sq.vld  = i_s_tvalid;
        n_sq.zero = (xc == '0) || ({1'b0, col} >= size) || ({1'b0, row} >= size);
        n_sq.rmin = RMIN_W'(kms * $signed({1'b0, xc}));
        n_sq.dr   = DR_W'(({1'b0, r_smooth} + ONE_MINUS_K) * xc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq.vld <= 1'b0;
        end else if (en) begin
            r_sq.vld <= n_sq.vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq.zero <= n_sq.zero;
            r_sq.rmin <= n_sq.rmin;
            r_sq.dr   <= n_sq.dr;
            r_d2      <= d2;
        end
    end

    t_sq_side            sq_side;
    logic [ROOT_W-1:0]   root;

    bfm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (r_sq),
        .i_val   ({r_d2, {(2*FRAC_BITS){1'b0}}}),
        .o_side  (sq_side),
        .o_root  (root)
    );

    // compare stage: position of r inside the falloff band
    logic signed [NUM_W-1:0] num;
    t_dv_side                n_dv, r_dv;
    logic [DR_W-1:0]         r_num, r_dr;

    always_comb begin
        num       = $signed({{(NUM_W-ROOT_W){1'b0}}, root}) - NUM_W'(sq_side.rmin);
        n_dv.vld  = sq_side.vld;
        n_dv.one  = num < 0;
        n_dv.zero = sq_side.zero || (!(num < 0) && (NUM_W'(sq_side.dr) <= num));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv.vld <= 1'b0;
        end else if (en) begin
            r_dv.vld <= n_dv.vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv.one  <= n_dv.one;
            r_dv.zero <= n_dv.zero;
            r_num     <= (n_dv.one || n_dv.zero) ? '0 : DR_W'(num);
            r_dr      <= sq_side.dr;
        end
    end

    t_dv_side            dv_side;
    logic [QUO_W-1:0]    rr;

    bfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (r_dv),
        .i_num   (r_num),
        .i_dr    (r_dr),
        .o_side  (dv_side),
        .o_quo   (rr)
    );

    // falloff stage: two-piece quadratic
    logic [Q_W-1:0]     rr2, u;
    logic [2*Q_W-1:0]   sq;
    logic [Q_W-1:0]     sqh, val;
    logic [Q_W-1:0]     r_val;
    logic               r_fv;

    always_comb begin
        rr2 = {rr, 1'b0};
        u   = rr2[Q_W-1] ? Q_W'({1'b1, {Q_W{1'b0}}} - {1'b0, rr2}) : rr2;
        sq  = u * u;
        sqh = Q_W'(sq >> (FRAC_BITS + 1));
        if (dv_side.zero) begin
            val = '0;
        end else if (dv_side.one) begin
            val = ONE_Q;
        end else if (rr2[Q_W-1]) begin
            val = sqh;
        end else begin
            val = ONE_Q - sqh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (en) begin
            r_fv <= dv_side.vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_val <= val;
        end
    end

    // opacity stage and output register
    logic [2*Q_W-1:0]   prod;
    logic [2*Q_W-1:0]   w;
    logic [Q_W-1:0]     r_w;
    logic               r_ov;

    always_comb begin
        prod = r_val * r_opac;
        w    = prod >> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_fv;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w <= (w > (2*Q_W)'(ONE_Q)) ? ONE_Q : w[Q_W-1:0];
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {{(24-Q_W){1'b0}}, r_w};
endmodule
`default_nettype wire

>>> src/bfm_sqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module bfm_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire bfm_pkg::t_sq_side           i_side,
    input  wire logic [bfm_pkg::SQ_IN_W-1:0] i_val,
    output bfm_pkg::t_sq_side                o_side,
    output logic [bfm_pkg::ROOT_W-1:0]       o_root
);
    import bfm_pkg::*;

    logic [SQ_IN_W-1:0] r_v   [0:ROOT_W];
    logic [SQ_IN_W-1:0] r_res [0:ROOT_W];
    t_sq_side           r_side[0:ROOT_W];
    logic [SQ_IN_W-1:0] n_v   [0:ROOT_W-1];
    logic [SQ_IN_W-1:0] n_res [0:ROOT_W-1];

    always_comb begin
        r_v[0]    = i_val;
        r_res[0]  = '0;
        r_side[0] = i_side;
    end

    always_comb begin
        logic [SQ_IN_W-1:0] bitv;
        logic [SQ_IN_W-1:0] sum;
        for (int i = 0; i < ROOT_W; i++) begin
            bitv = SQ_IN_W'(1) << (2 * (ROOT_W - 1 - i));
            sum  = r_res[i] + bitv;
            if (r_v[i] >= sum) begin
                n_v[i]   = r_v[i] - sum;
                n_res[i] = (r_res[i] >> 1) + bitv;
            end else begin
                n_v[i]   = r_v[i];
                n_res[i] = r_res[i] >> 1;
            end
        end
    end

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[g+1].vld <= 1'b0;
            end else if (i_en) begin
                r_side[g+1].vld <= r_side[g].vld;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[g+1]         <= n_v[g];
                r_res[g+1]       <= n_res[g];
                r_side[g+1].zero <= r_side[g].zero;
                r_side[g+1].rmin <= r_side[g].rmin;
                r_side[g+1].dr   <= r_side[g].dr;
            end
        end
    end

    assign o_side = r_side[ROOT_W];
    assign o_root = r_res[ROOT_W][ROOT_W-1:0];
endmodule
`default_nettype wire

>>> src/bfm_div.sv
// pipelined restoring divider giving the fractional quotient num/dr, one bit per stage
`default_nettype none
module bfm_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire bfm_pkg::t_dv_side         i_side,
    input  wire logic [bfm_pkg::DR_W-1:0]  i_num,
    input  wire logic [bfm_pkg::DR_W-1:0]  i_dr,
    output bfm_pkg::t_dv_side              o_side,
    output logic [bfm_pkg::QUO_W-1:0]      o_quo
);
    import bfm_pkg::*;

    logic [DR_W-1:0]  r_rem [0:QUO_W];
    logic [DR_W-1:0]  r_dr  [0:QUO_W];
    logic [QUO_W-1:0] r_q   [0:QUO_W];
    t_dv_side         r_side[0:QUO_W];
    logic [DR_W-1:0]  n_rem [0:QUO_W-1];
    logic [QUO_W-1:0] n_q   [0:QUO_W-1];

    always_comb begin
        r_rem[0]  = i_num;
        r_dr[0]   = i_dr;
        r_q[0]    = '0;
        r_side[0] = i_side;
    end

    always_comb begin
        logic [DR_W:0] t;
        for (int i = 0; i < QUO_W; i++) begin
            t = {r_rem[i], 1'b0};
            if (t >= {1'b0, r_dr[i]}) begin
                n_rem[i] = DR_W'(t - {1'b0, r_dr[i]});
                n_q[i]   = {r_q[i][QUO_W-2:0], 1'b1};
            end else begin
                n_rem[i] = DR_W'(t);
                n_q[i]   = {r_q[i][QUO_W-2:0], 1'b0};
            end
        end
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[g+1].vld <= 1'b0;
            end else if (i_en) begin
                r_side[g+1].vld <= r_side[g].vld;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]       <= n_rem[g];
                r_dr[g+1]        <= r_dr[g];
                r_q[g+1]         <= n_q[g];
                r_side[g+1].zero <= r_side[g].zero;
                r_side[g+1].one  <= r_side[g].one;
            end
        end
    end

    assign o_side = r_side[QUO_W];
    assign o_quo  = r_q[QUO_W];
endmodule
`default_nettype wire
